/* src/rbsi_pkg.sv */
// Package with types, constants and helper functions for the ray versus box slab test.
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int unsigned NUM_AX     = 3;
  localparam int unsigned NUM_LANES  = 2 * NUM_AX;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CW         = 32;
  localparam int unsigned DW         = CW + 1;
  localparam int unsigned QW         = DW + FRAC_BITS;
  localparam int unsigned DIV_STEPS  = 7;
  localparam int unsigned DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned EPS_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_EPSILON = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] SPAN_LIMIT_RST  = LIMIT_W'(65536000);
  localparam logic [EPS_W-1:0]   DIR_EPSILON_RST = EPS_W'(1);

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [QW-1:0] numq;
    logic [CW-1:0] rem;
    logic [CW-1:0] dvs;
    logic          neg;
  } div_lane_t;

  typedef struct packed {
    logic signed [CW-1:0] near;
    logic signed [CW-1:0] far;
    logic                 miss;
  } span_t;

  function automatic div_lane_t div_steps(div_lane_t l);
    div_lane_t   r;
    logic [DW-1:0] trial;
    logic        nb;
    r = l;
    for (int i = 0; i < DIV_STEPS; i++) begin
      nb     = r.numq[QW-1];
      trial  = {r.rem, nb} - {1'b0, r.dvs};
      r.numq = {r.numq[QW-2:0], ~trial[DW-1]};
      if (!trial[DW-1]) begin
        r.rem = trial[CW-1:0];
      end else begin
        r.rem = {r.rem[CW-2:0], nb};
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_quot(logic [QW-1:0] q, logic neg);
    logic signed [CW-1:0] t;
    if (neg) begin
      if ((|q[QW-1:CW]) || (q[CW-1] && (|q[CW-2:0]))) begin
        t = T_MIN;
      end else begin
        t = -$signed(q[CW-1:0]);
      end
    end else begin
      if (|q[QW-1:CW-1]) begin
        t = T_MAX;
      end else begin
        t = $signed(q[CW-1:0]);
      end
    end
    return t;
  endfunction

  function automatic span_t axis_step(span_t s, logic par, logic outside,
                                      logic signed [CW-1:0] tn,
                                      logic signed [CW-1:0] tf);
    span_t r;
    r = s;
    if (!s.miss) begin
      if (par) begin
        r.miss = outside;
      end else begin
        if (tn > s.near) begin
          r.near = tn;
        end
        if (tf < s.far) begin
          r.far = tf;
        end
        r.miss = (r.near > r.far);
      end
    end
    return r;
  endfunction

endpackage

/* src/ray_box_slab_intersection.sv */
// Top level of the pipelined ray versus axis-aligned box slab test.
`timescale 1ns / 1ps
// The input channel (valid_i, stall_o) takes one ray and one box per beat:
// origin, direction and box corners, all signed Q16.16. The output channel
// (valid_o, stall_i) returns one beat per input beat, in order, with the hit
// flag and the near and far distances of the span.
// One beat is accepted in every cycle while the output is not stalled. Each
// beat passes an input stage, a load stage for the six restoring dividers,
// seven divider stages of seven quotient bits each, saturation, slab
// ordering, one stage per axis that narrows the span and an output register.
// The configuration port writes span_limit (index 0) and dir_epsilon
// (index 1) at an edge with cfg_we_i high; other indexes are ignored.
// Writes belong to idle periods.
// Reset empties the pipeline and restores both registers to their defaults.
// When the receiver stalls a waiting result, the whole pipeline holds and
// stall_o is raised, so no beat is lost or repeated.
module ray_box_slab_intersection
  import rbsi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [LIMIT_W-1:0]       cfg_data_i,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [CW-1:0]     origin_x_i,
  input  logic signed [CW-1:0]     origin_y_i,
  input  logic signed [CW-1:0]     origin_z_i,
  input  logic signed [CW-1:0]     dir_x_i,
  input  logic signed [CW-1:0]     dir_y_i,
  input  logic signed [CW-1:0]     dir_z_i,
  input  logic signed [CW-1:0]     lo_x_i,
  input  logic signed [CW-1:0]     lo_y_i,
  input  logic signed [CW-1:0]     lo_z_i,
  input  logic signed [CW-1:0]     hi_x_i,
  input  logic signed [CW-1:0]     hi_y_i,
  input  logic signed [CW-1:0]     hi_z_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     hit_o,
  output logic [LIMIT_W-1:0]       span_near_o,
  output logic signed [CW-1:0]     span_far_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic [EPS_W-1:0]   eps_q;
  logic               en;

  logic signed [CW-1:0] org [NUM_AX];
  logic signed [CW-1:0] dir [NUM_AX];
  logic signed [CW-1:0] blo [NUM_AX];
  logic signed [CW-1:0] bhi [NUM_AX];

  // Input stage.
  logic                 v1_q;
  logic signed [DW-1:0] dlo_q [NUM_AX];
  logic signed [DW-1:0] dhi_q [NUM_AX];
  logic signed [CW-1:0] dir_q [NUM_AX];
  logic [NUM_AX-1:0]    par1_q, out1_q;
  logic [CW-1:0]        dmag  [NUM_AX];
  logic [NUM_AX-1:0]    par_d, outs_d;

  // Divider stages.
  logic                 dv_q   [DIV_STAGES+1];
  div_lane_t            lane_q [DIV_STAGES+1][NUM_LANES];
  logic [NUM_AX-1:0]    dpar_q [DIV_STAGES+1];
  logic [NUM_AX-1:0]    dout_q [DIV_STAGES+1];
  div_lane_t            lane_d [NUM_LANES];

  // Saturation and ordering stages.
  logic                 sv_q, ov_q;
  logic signed [CW-1:0] t_q  [NUM_LANES];
  logic signed [CW-1:0] tn_q [NUM_AX];
  logic signed [CW-1:0] tf_q [NUM_AX];
  logic [NUM_AX-1:0]    spar_q, sout_q, opar_q, oout_q;

  // Axis stages.
  logic                 av_q [NUM_AX];
  span_t                sp_q [NUM_AX];
  logic signed [CW-1:0] atn_q [NUM_AX][NUM_AX];
  logic signed [CW-1:0] atf_q [NUM_AX][NUM_AX];
  logic [NUM_AX-1:0]    apar_q [NUM_AX];
  logic [NUM_AX-1:0]    aout_q [NUM_AX];
  span_t                sp_init;

  logic                 vo_q, hit_q;
  logic [LIMIT_W-1:0]   near_q;
  logic signed [CW-1:0] far_q;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};
  assign blo = '{lo_x_i, lo_y_i, lo_z_i};
  assign bhi = '{hi_x_i, hi_y_i, hi_z_i};

  assign en      = !vo_q || !stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SPAN_LIMIT_RST;
      eps_q   <= DIR_EPSILON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPAN_LIMIT:  limit_q <= cfg_data_i;
        CFG_DIR_EPSILON: eps_q   <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      dmag[a]  = dir[a][CW-1] ? CW'(-dir[a]) : CW'(dir[a]);
      par_d[a] = (dir[a] == '0) || (dmag[a] < {{(CW-EPS_W){1'b0}}, eps_q});
      outs_d[a] = (org[a] < blo[a]) || (org[a] > bhi[a]);
    end
  end

  always_comb begin
    logic [DW-1:0] mag;
    logic          dneg;
    logic [CW-1:0] dm;
    for (int l = 0; l < NUM_LANES; l++) begin
      dneg = dir_q[l % NUM_AX][CW-1];
      dm   = dneg ? CW'(-dir_q[l % NUM_AX]) : CW'(dir_q[l % NUM_AX]);
      if (l < NUM_AX) begin
        mag = dlo_q[l % NUM_AX][DW-1] ? DW'(-dlo_q[l % NUM_AX]) : DW'(dlo_q[l % NUM_AX]);
        lane_d[l].neg = dlo_q[l % NUM_AX][DW-1] ^ dneg;
      end else begin
        mag = dhi_q[l % NUM_AX][DW-1] ? DW'(-dhi_q[l % NUM_AX]) : DW'(dhi_q[l % NUM_AX]);
        lane_d[l].neg = dhi_q[l % NUM_AX][DW-1] ^ dneg;
      end
      lane_d[l].numq = {mag, {FRAC_BITS{1'b0}}};
      lane_d[l].rem  = '0;
      lane_d[l].dvs  = par1_q[l % NUM_AX] ? CW'(1) : dm;
    end
  end

  assign sp_init = '{near: '0, far: $signed({1'b0, limit_q}), miss: 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_q[k] <= 1'b0;
      end
      for (int a = 0; a < NUM_AX; a++) begin
        av_q[a] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= valid_i;
      dv_q[0] <= v1_q;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      sv_q    <= dv_q[DIV_STAGES];
      ov_q    <= sv_q;
      av_q[0] <= ov_q;
      for (int a = 1; a < NUM_AX; a++) begin
        av_q[a] <= av_q[a-1];
      end
      vo_q <= av_q[NUM_AX-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_AX; a++) begin
        dlo_q[a] <= DW'(blo[a]) - DW'(org[a]);
        dhi_q[a] <= DW'(bhi[a]) - DW'(org[a]);
        dir_q[a] <= dir[a];
      end
      par1_q <= par_d;
      out1_q <= outs_d;

      lane_q[0] <= lane_d;
      dpar_q[0] <= par1_q;
      dout_q[0] <= out1_q;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          lane_q[k][l] <= div_steps(lane_q[k-1][l]);
        end
        dpar_q[k] <= dpar_q[k-1];
        dout_q[k] <= dout_q[k-1];
      end

      for (int l = 0; l < NUM_LANES; l++) begin
        t_q[l] <= sat_quot(lane_q[DIV_STAGES][l].numq, lane_q[DIV_STAGES][l].neg);
      end
      spar_q <= dpar_q[DIV_STAGES];
      sout_q <= dout_q[DIV_STAGES];

      for (int a = 0; a < NUM_AX; a++) begin
        if (t_q[a] > t_q[a+NUM_AX]) begin
          tn_q[a] <= t_q[a+NUM_AX];
          tf_q[a] <= t_q[a];
        end else begin
          tn_q[a] <= t_q[a];
          tf_q[a] <= t_q[a+NUM_AX];
        end
      end
      opar_q <= spar_q;
      oout_q <= sout_q;

      sp_q[0]   <= axis_step(sp_init, opar_q[0], oout_q[0], tn_q[0], tf_q[0]);
      atn_q[0]  <= tn_q;
      atf_q[0]  <= tf_q;
      apar_q[0] <= opar_q;
      aout_q[0] <= oout_q;
      for (int a = 1; a < NUM_AX; a++) begin
        sp_q[a]   <= axis_step(sp_q[a-1], apar_q[a-1][a], aout_q[a-1][a],
                               atn_q[a-1][a], atf_q[a-1][a]);
        atn_q[a]  <= atn_q[a-1];
        atf_q[a]  <= atf_q[a-1];
        apar_q[a] <= apar_q[a-1];
        aout_q[a] <= aout_q[a-1];
      end

      hit_q  <= !sp_q[NUM_AX-1].miss && (sp_q[NUM_AX-1].near < sp_q[NUM_AX-1].far);
      near_q <= sp_q[NUM_AX-1].near[LIMIT_W-1:0];
      far_q  <= sp_q[NUM_AX-1].far;
    end
  end

  assign valid_o     = vo_q;
  assign hit_o       = hit_q;
  assign span_near_o = near_q;
  assign span_far_o  = far_q;

  a_stall_only_on_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("Input stalled without a held output beat.");

  a_hit_span_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> $signed({1'b0, span_near_o}) < span_far_o)
    else $error("Hit reported with an empty span.");

  a_far_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> span_far_o <= $signed({1'b0, limit_q}))
    else $error("Far distance exceeds the span limit.");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the ray versus axis-aligned box slab test.
`timescale 1ns / 1ps
module tb_top;
  import rbsi_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_box_t;

  typedef struct packed {
    logic               hit;
    logic [LIMIT_W-1:0] near;
    logic signed [CW-1:0] far;
  } slab_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SPAN_LIMIT;
  logic [LIMIT_W-1:0] cfg_data_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  ray_box_t beat = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic hit_o;
  logic [LIMIT_W-1:0] span_near_o;
  logic signed [CW-1:0] span_far_o;

  ray_box_t pending_rays[$];
  slab_result_t expected_spans[$];
  logic [LIMIT_W-1:0] cur_limit = SPAN_LIMIT_RST;
  logic [EPS_W-1:0] cur_eps = DIR_EPSILON_RST;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  longint cycles = 0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  ray_box_slab_intersection dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i, .stall_o,
    .origin_x_i(beat.ox), .origin_y_i(beat.oy), .origin_z_i(beat.oz),
    .dir_x_i(beat.dx), .dir_y_i(beat.dy), .dir_z_i(beat.dz),
    .lo_x_i(beat.lx), .lo_y_i(beat.ly), .lo_z_i(beat.lz),
    .hi_x_i(beat.hx), .hi_y_i(beat.hy), .hi_z_i(beat.hz),
    .valid_o, .stall_i, .hit_o, .span_near_o, .span_far_o
  );

  function automatic longint slab_time(longint edge_c, longint org, longint d);
    longint q;
    q = ((edge_c - org) * 65536) / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic slab_result_t intersect_box(ray_box_t r);
    longint o[3], d[3], lo[3], hi[3];
    longint near_t, far_t, t1, t2, t, mag;
    bit hit;
    slab_result_t res;
    o = '{r.ox, r.oy, r.oz};
    d = '{r.dx, r.dy, r.dz};
    lo = '{r.lx, r.ly, r.lz};
    hi = '{r.hx, r.hy, r.hz};
    near_t = 0;
    far_t = longint'(cur_limit);
    hit = 1'b1;
    for (int ax = 0; ax < 3; ax++) begin
      mag = d[ax] < 0 ? -d[ax] : d[ax];
      if (d[ax] == 0 || mag < longint'(cur_eps)) begin
        if (o[ax] < lo[ax] || o[ax] > hi[ax]) begin
          hit = 1'b0;
          break;
        end
      end else begin
        t1 = slab_time(lo[ax], o[ax], d[ax]);
        t2 = slab_time(hi[ax], o[ax], d[ax]);
        if (t1 > t2) begin
          t = t1; t1 = t2; t2 = t;
        end
        if (t1 > near_t) near_t = t1;
        if (t2 < far_t) far_t = t2;
        if (near_t > far_t) begin
          hit = 1'b0;
          break;
        end
      end
    end
    if (hit && !(near_t < far_t)) hit = 1'b0;
    res.hit = hit;
    res.near = near_t[LIMIT_W-1:0];
    res.far = far_t[CW-1:0];
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 20))) - 10;
      2: return $urandom_range(0, 1) ? T_MAX : T_MIN;
      default: return $signed(32'($urandom_range(0, 40 << 16))) - (20 << 16);
    endcase
  endfunction

  function automatic ray_box_t rand_ray();
    ray_box_t r;
    logic signed [CW-1:0] a, b;
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
    if ($urandom_range(0, 9) == 0) r.dx = 0;
    if ($urandom_range(0, 9) == 0) r.dy = 0;
    if ($urandom_range(0, 9) == 0) r.dz = 0;
    for (int ax = 0; ax < 3; ax++) begin
      a = rand_coord();
      b = rand_coord();
      if ($urandom_range(0, 4) != 0 && a > b) begin
        logic signed [CW-1:0] s;
        s = a; a = b; b = s;
      end
      case (ax)
        0: begin r.lx = a; r.hx = b; end
        1: begin r.ly = a; r.hy = b; end
        default: begin r.lz = a; r.hz = b; end
      endcase
    end
    return r;
  endfunction

  function automatic ray_box_t make_ray(int o, int d, int l, int h);
    ray_box_t r;
    r.ox = o; r.oy = o; r.oz = o;
    r.dx = d; r.dy = d; r.dz = d;
    r.lx = l; r.ly = l; r.lz = l;
    r.hx = h; r.hy = h; r.hz = h;
    return r;
  endfunction

  task automatic drain_and_settle();
    while (pending_rays.size() != 0 || expected_spans.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SPAN_LIMIT) cur_limit = val;
    else if (idx == CFG_DIR_EPSILON) cur_eps = val[EPS_W-1:0];
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        if (!hold_send && pending_rays.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          beat <= pending_rays[0];
          expected_spans.push_back(intersect_box(pending_rays.pop_front()));
        end else begin
          valid_i <= 1'b0;
        end
      end else if (!valid_i && !hold_send && pending_rays.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        valid_i <= 1'b1;
        beat <= pending_rays[0];
        expected_spans.push_back(intersect_box(pending_rays.pop_front()));
      end
      stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    slab_result_t want;
    cycles <= cycles + 1;
    in_taken <= valid_i && !stall_o;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_spans.size() == 0) begin
        $error("unexpected result beat");
        errors = errors + 1;
      end else begin
        want = expected_spans.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          errors = errors + 1;
        end
        if (span_near_o !== want.near) begin
          $error("span_near: expected %0d, got %0d", want.near, span_near_o);
          errors = errors + 1;
        end
        if (span_far_o !== want.far) begin
          $error("span_far: expected %0d, got %0d", want.far, span_far_o);
          errors = errors + 1;
        end
      end
    end
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    ray_box_t r;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    pending_rays.push_back(make_ray(0, 65536, 65536, 2 << 16));
    pending_rays.push_back(make_ray(0, -65536, -(2 << 16), -65536));
    pending_rays.push_back(make_ray(0, 0, -1, 1));
    pending_rays.push_back(make_ray(5 << 16, 0, -1, 1));
    pending_rays.push_back(make_ray(0, 65536, 2 << 16, 65536));
    pending_rays.push_back(make_ray(0, 1, T_MIN, T_MAX));
    pending_rays.push_back(make_ray(T_MIN, 1, T_MAX, T_MAX));
    pending_rays.push_back(make_ray(T_MAX, -1, T_MIN, T_MIN));
    pending_rays.push_back(make_ray(T_MIN, T_MAX, T_MIN, T_MAX));
    pending_rays.push_back(make_ray(0, T_MIN, T_MIN, T_MAX));
    pending_rays.push_back(make_ray(0, 65536, 0, 0));
    pending_rays.push_back(make_ray(-1, -1, -1, -1));
    r = make_ray(0, 65536, -65536, 65536);
    r.dy = 0; r.oy = 3 << 16;
    pending_rays.push_back(r);
    drain_and_settle();

    write_reg(CFG_DIR_EPSILON, 16'hFFFF);
    write_reg(CFG_SPAN_LIMIT, '0);
    write_reg(2'd3, '1);
    pending_rays.push_back(make_ray(0, 16'hFFFE, -1, 1));
    pending_rays.push_back(make_ray(0, 16'hFFFF, -65536, 65536));
    pending_rays.push_back(make_ray(0, -65535, -65536, 65536));
    pending_rays.push_back(make_ray(0, T_MIN, -1, 1));
    drain_and_settle();

    write_reg(CFG_SPAN_LIMIT, '1);
    write_reg(CFG_DIR_EPSILON, 16'd1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 38 : phase == 1 ? 82 : 0;
      recv_idle_pct = phase == 0 ? 82 : phase == 1 ? 38 : 0;
      for (int i = 0; i < 500; i++) pending_rays.push_back(rand_ray());
      while (pending_rays.size() > 250) @(posedge clk_i);
      hold_send = 1'b1;
      while (expected_spans.size() != 0) @(posedge clk_i);
      hold_send = 1'b0;
      drain_and_settle();
      write_reg(CFG_SPAN_LIMIT, LIMIT_W'($urandom_range(0, 32'h7FFFFFFF)));
      write_reg(CFG_DIR_EPSILON, LIMIT_W'($urandom_range(1, 65535)));
    end
    drain_and_settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
